// ----- sv/bounded_list_insert_remove_core_defines.svh -----
// Assertion macros for the bounded list core.
// Included by the top level; expects clk and arst_n in scope.
`ifndef BOUNDED_LIST_INSERT_REMOVE_CORE_DEFINES_SVH
`define BOUNDED_LIST_INSERT_REMOVE_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BLIR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define BLIR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/blir_pkg.sv -----
// Shared types and constants for the bounded list core.
// No dependencies.
package blir_pkg;

	localparam int CapacityDefault = 16;
	localparam int WordBitsDefault = 32;

	localparam int ModeW  = 3;
	localparam int PosW   = 5;
	localparam int ItemW  = 32;
	localparam int CountW = 5;

	typedef enum logic [ModeW-1:0] {
		MODE_PUSH   = 3'd0,
		MODE_INSERT = 3'd1,
		MODE_REMOVE = 3'd2,
		MODE_POP    = 3'd3,
		MODE_GET    = 3'd4
	} mode_t;

	// Per-transaction command broadcast to every cell in the chain.
	typedef struct packed {
		logic wr;         // write the new word at the target index
		logic shift_up;   // cells above the target take the left neighbor
		logic shift_down; // cells at or above the target take the right neighbor
		logic rd;         // the target cell drives its word onto the read bus
	} cell_ctrl_t;

endpackage

// ----- sv/blir_cell.sv -----
// One storage cell of the list: holds the entry at a fixed index.
// Depends on blir_pkg.
module blir_cell import blir_pkg::*; #(
	parameter int INDEX     = 0,
	parameter int IDX_W     = 4,
	parameter int WORD_BITS = WordBitsDefault
) (
	input  logic                 clk,
	input  cell_ctrl_t           ctrl,
	input  logic [IDX_W-1:0]     tgt,
	input  logic [WORD_BITS-1:0] din,
	input  logic [WORD_BITS-1:0] left_word,
	input  logic [WORD_BITS-1:0] right_word,
	output logic [WORD_BITS-1:0] word,
	output logic [WORD_BITS-1:0] rd_word
);

	logic [WORD_BITS-1:0] word_q;
	logic                 at_tgt;
	logic                 above_tgt;

	assign at_tgt    = (tgt == IDX_W'(INDEX));
	assign above_tgt = (IDX_W'(INDEX) > tgt);

	// Entries are undefined until written, so the data needs no reset.
	always_ff @(posedge clk) begin
		if (ctrl.wr && at_tgt) begin
			word_q <= din;
		end else if (ctrl.shift_up && above_tgt) begin
			word_q <= left_word;
		end else if (ctrl.shift_down && (above_tgt || at_tgt)) begin
			word_q <= right_word;
		end
	end

	assign word    = word_q;
	assign rd_word = (ctrl.rd && at_tgt) ? word_q : '0;

endmodule

// ----- sv/bounded_list_insert_remove_core.sv -----
// Top level of the bounded list core: request decode, chain of cells, result register.
// Depends on blir_pkg, blir_cell and bounded_list_insert_remove_core_defines.svh.

// Fixed-capacity ordered list of data words. Each input transaction carries one request
// (push, insert, remove, pop or get) and produces exactly one result transaction with a
// success flag, the word read and the entry count after the request. Each entry lives in
// its own cell; on insert all cells above the target position, and on remove all cells at
// or above it, move to their neighbor at the same clock edge. The result is held in an
// output register, so a new request is taken in every cycle in which that register is empty
// or its result is being taken. Entries hold no reset value; a get only ever reads
// positions below the count.
module bounded_list_insert_remove_core import blir_pkg::*; #(
	parameter int CAPACITY  = CapacityDefault,
	parameter int WORD_BITS = WordBitsDefault
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [ModeW-1:0]  mode,
	input  logic [PosW-1:0]   position,
	input  logic [ItemW-1:0]  item_word,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              ok,
	output logic [ItemW-1:0]  read_word,
	output logic [CountW-1:0] item_count
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > PosW) ? CNT_W : PosW;

	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     count_next;
	logic                 out_valid_q;
	logic                 ok_q;
	logic [ItemW-1:0]     read_word_q;
	logic [CountW-1:0]    item_count_q;

	logic                 accept;
	logic                 full;
	logic                 empty;
	logic [CMP_W-1:0]     pos_x;
	logic [CMP_W-1:0]     cnt_x;
	logic                 ok_c;
	logic                 use_count_tgt;
	cell_ctrl_t           ctrl;
	logic [IDX_W-1:0]     tgt;
	logic [WORD_BITS-1:0] din;
	logic [WORD_BITS-1:0] rd_or;

	logic [WORD_BITS-1:0] cell_word [CAPACITY];
	logic [WORD_BITS-1:0] cell_rd   [CAPACITY];

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	assign full  = (count_q == CNT_W'(CAPACITY));
	assign empty = (count_q == '0);
	assign pos_x = CMP_W'(position);
	assign cnt_x = CMP_W'(count_q);
	assign din   = WORD_BITS'(item_word);

	// Decode the request; the cell command is only raised for an accepted transaction.
	always_comb begin
		ok_c          = 1'b0;
		use_count_tgt = 1'b0;
		ctrl          = '0;
		count_next    = count_q;
		case (mode)
			MODE_PUSH: begin
				ok_c          = !full;
				use_count_tgt = 1'b1;
				ctrl.wr       = !full;
				if (!full) count_next = count_q + CNT_W'(1);
			end
			MODE_INSERT: begin
				ok_c          = !full && (pos_x <= cnt_x);
				ctrl.wr       = ok_c;
				ctrl.shift_up = ok_c;
				if (ok_c) count_next = count_q + CNT_W'(1);
			end
			MODE_REMOVE: begin
				ok_c            = (pos_x < cnt_x);
				ctrl.shift_down = ok_c;
				if (ok_c) count_next = count_q - CNT_W'(1);
			end
			MODE_POP: begin
				ok_c = !empty;
				if (!empty) count_next = count_q - CNT_W'(1);
			end
			MODE_GET: begin
				ok_c    = (pos_x < cnt_x);
				ctrl.rd = ok_c;
			end
			default: begin
				ok_c = 1'b0;
			end
		endcase
		if (!accept) begin
			ctrl       = '0;
			count_next = count_q;
		end
	end

	assign tgt = use_count_tgt ? count_q[IDX_W-1:0] : pos_x[IDX_W-1:0];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [WORD_BITS-1:0] left_w;
		logic [WORD_BITS-1:0] right_w;
		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_left
			assign left_w = cell_word[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_right
			assign right_w = cell_word[i+1];
		end
		blir_cell #(
			.INDEX     (i),
			.IDX_W     (IDX_W),
			.WORD_BITS (WORD_BITS)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.tgt        (tgt),
			.din        (din),
			.left_word  (left_w),
			.right_word (right_w),
			.word       (cell_word[i]),
			.rd_word    (cell_rd[i])
		);
	end

	// At most one cell drives a nonzero read word, so an OR collects it.
	always_comb begin
		rd_or = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_or = rd_or | cell_rd[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ok_q         <= ok_c;
			read_word_q  <= ItemW'(rd_or);
			item_count_q <= CountW'(count_next);
		end
	end

	assign out_valid  = out_valid_q;
	assign ok         = ok_q;
	assign read_word  = read_word_q;
	assign item_count = item_count_q;

`include "bounded_list_insert_remove_core_defines.svh"

	`BLIR_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(CAPACITY), "count exceeds capacity")
	`BLIR_ASSERT_NEXT(a_fail_keeps_count, accept && !ok_c, $stable(count_q), "failed request changed count")
	`BLIR_ASSERT_NEXT(a_result_count, accept, out_valid_q && item_count_q == CountW'(count_q), "result count mismatch")

endmodule
